// ===== rtl/gbmf_pkg.sv =====
// Package for the grayscale box mean filter.
// Shared widths, defaults, register indexes, reset values and request modes; no dependencies.
`timescale 1ns / 1ps
package gbmf_pkg;

   // Pixel and register widths
   localparam int PIX_W      = 8;
   localparam int COORD_W    = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;
   localparam int RADIUS_W   = 3;

   // Parameter defaults
   localparam int MAX_DIM_DEF    = 256;
   localparam int MAX_RADIUS_DEF = 7;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd2;

   // Register reset values
   localparam logic [RADIUS_W-1:0]   RADIUS_RST = 3'd1;
   localparam logic [CSR_DATA_W-1:0] DIM_RST    = 9'd256;

   // Request modes
   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_FILTER = 1'b1;

endpackage

// ===== rtl/gbmf_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No package dependencies.
`timescale 1ns / 1ps
module gbmf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/gbmf_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Uses no package items; started by the filter sequencer.
`timescale 1ns / 1ps
module gbmf_div #(
   parameter int DVD_W = 18,
   parameter int DVS_W = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W:0]   shifted;
   logic [DVS_W:0]   diff;
   logic             ge;

   // One trial subtraction per cycle
   assign shifted = {rem_ff, quo_ff[DVD_W-1]};
   assign ge      = shifted >= {1'b0, dvs_ff};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DVD_W);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/grayscale_box_mean_filter.sv =====
// Grayscale box mean filter: frame memory, window sequencer, divider.
// Depends on gbmf_pkg, gbmf_ram and gbmf_div.
//
// Usage:
//  - req_ channel: mode 0 writes req_pixel_in at (req_row, req_col) into the
//    frame memory; mode 1 asks for the mean of the (2*radius+1)^2 window
//    around (req_row, req_col). Neighbors outside the image read row 0 or
//    column 0 of their axis.
//  - rsp_ channel: one beat per filter request, none per load. A request
//    outside the configured image returns rsp_bad_request=1, pixel 0.
//  - csr_ channel: index 0 radius, 1 image width, 2 image height; always
//    ready, other indexes ignored. Write only while the block is idle.
// Sequence:
//  - A load writes the frame memory on its beat; req_ready stays high.
//  - A filter reads the frame memory once per window pixel through the
//    single read port, then runs a restoring divide at one bit per cycle
//    (SUMW = 16 bits at the default radius limit). A bad request skips
//    the scan and the divide and goes straight to the result hold state.
//  - The result sits in an output register; a stalled rsp_ready holds it
//    while the next request is already taken and worked on.
// Reset: registers return to radius 1, 256 x 256; the frame memory is not
// cleared and must be loaded before it is filtered.
`timescale 1ns / 1ps
module grayscale_box_mean_filter
   import gbmf_pkg::*;
#(
   parameter int MAX_DIM    = MAX_DIM_DEF,
   parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_mode,
   input  logic [COORD_W-1:0]    req_row,
   input  logic [COORD_W-1:0]    req_col,
   input  logic [PIX_W-1:0]      req_pixel_in,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [PIX_W-1:0]      rsp_pixel_out,
   output logic                  rsp_bad_request,
   // register write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int DIMW  = $clog2(MAX_DIM + 1);
   localparam int CW    = (DIMW > CSR_DATA_W) ? DIMW : CSR_DATA_W;
   localparam int SW    = CW + 1;
   localparam int AD    = $clog2(MAX_DIM);
   localparam int RW    = $clog2(MAX_RADIUS + 1);
   localparam int RCW   = (RW > RADIUS_W) ? RW : RADIUS_W;
   localparam int CTW   = RW + 1;
   localparam int WIN   = 2 * MAX_RADIUS + 1;
   localparam int SUMW  = $clog2(WIN * WIN * ((1 << PIX_W) - 1) + 1);
   localparam int AREAW = $clog2(WIN * WIN + 1);
   localparam int DEPTH = 1 << (2 * AD);

   // Sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_START = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_HOLD  = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [RADIUS_W-1:0]   radius_ff, radius_in;
   logic [CSR_DATA_W-1:0] width_ff, width_in;
   logic [CSR_DATA_W-1:0] height_ff, height_in;
   logic [CW-1:0]         row_ff, row_in;
   logic [CW-1:0]         col_ff, col_in;
   logic [RW-1:0]         r_ff, r_in;
   logic [CTW-1:0]        lim_ff, lim_in;
   logic [CTW-1:0]        i_ff, i_in;
   logic [CTW-1:0]        j_ff, j_in;
   logic [AREAW-1:0]      area_ff, area_in;
   logic [SUMW-1:0]       sum_ff, sum_in;
   logic                  rd_pend_ff, rd_pend_in;
   logic [PIX_W-1:0]      res_ff, res_in;
   logic                  bad_ff, bad_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]      rsp_pixel_ff, rsp_pixel_in;
   logic                  rsp_bad_ff, rsp_bad_in;

   logic                  req_fire;
   logic                  csr_fire;
   logic [CW-1:0]         req_row_ext, req_col_ext;
   logic [CW-1:0]         w_sat, h_sat;
   logic [RCW-1:0]        r_sat;
   logic [RW-1:0]         r_eff;
   logic [RW:0]           side;
   logic [2*RW+1:0]       area_full;
   logic                  req_bad;

   logic [SW-1:0]         ty, ty_m, tx, tx_m, r_ext;
   logic [SW-1:0]         y_fold, x_fold;
   logic                  wr_en;
   logic [2*AD-1:0]       wr_addr, rd_addr;
   logic                  rd_en;
   logic [PIX_W-1:0]      rd_data;
   logic                  div_start, div_done;
   logic [SUMW-1:0]       quotient;
   logic                  out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid & req_ready;
   assign csr_fire  = csr_valid & csr_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;

   // Register file
   always_comb begin
      radius_in = radius_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_fire) begin
         case (csr_index)
            CSR_RADIUS: radius_in = csr_wdata[RADIUS_W-1:0];
            CSR_WIDTH:  width_in  = csr_wdata;
            CSR_HEIGHT: height_in = csr_wdata;
            default:    ;
         endcase
      end
   end

   // Saturated configuration
   assign w_sat = (CW'(width_ff) > CW'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(width_ff);
   assign h_sat = (CW'(height_ff) > CW'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(height_ff);
   assign r_sat = (RCW'(radius_ff) > RCW'(MAX_RADIUS)) ? RCW'(MAX_RADIUS)
                                                       : RCW'(radius_ff);
   assign r_eff     = r_sat[RW-1:0];
   assign side      = {r_eff, 1'b1};
   assign area_full = (2*RW+2)'(side) * (2*RW+2)'(side);

   assign req_row_ext = CW'(req_row);
   assign req_col_ext = CW'(req_col);
   assign req_bad     = (req_row_ext >= h_sat) || (req_col_ext >= w_sat);

   // Frame write on a load beat inside storage
   assign wr_en   = req_fire && (req_mode == MODE_LOAD) &&
                    (req_row_ext < CW'(MAX_DIM)) && (req_col_ext < CW'(MAX_DIM));
   assign wr_addr = {req_row_ext[AD-1:0], req_col_ext[AD-1:0]};

   // Neighbor coordinate fold: out of range maps to 0
   assign r_ext  = SW'(r_ff);
   assign ty     = SW'(row_ff) + SW'(i_ff);
   assign ty_m   = ty - r_ext;
   assign y_fold = ((ty < r_ext) || (ty_m >= SW'(h_sat))) ? '0 : ty_m;
   assign tx     = SW'(col_ff) + SW'(j_ff);
   assign tx_m   = tx - r_ext;
   assign x_fold = ((tx < r_ext) || (tx_m >= SW'(w_sat))) ? '0 : tx_m;

   assign rd_en   = (state_ff == ST_SCAN);
   assign rd_addr = {y_fold[AD-1:0], x_fold[AD-1:0]};

   assign div_start = (state_ff == ST_START);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      r_in         = r_ff;
      lim_in       = lim_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      area_in      = area_ff;
      sum_in       = sum_ff;
      res_in       = res_ff;
      bad_in       = bad_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pixel_in = rsp_pixel_ff;
      rsp_bad_in   = rsp_bad_ff;
      rd_pend_in   = rd_en;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // accumulate the pixel read in the previous cycle
      if (rd_pend_ff) begin
         sum_in = sum_ff + SUMW'(rd_data);
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_mode == MODE_FILTER)) begin
               row_in  = req_row_ext;
               col_in  = req_col_ext;
               r_in    = r_eff;
               lim_in  = {r_eff, 1'b0};
               area_in = area_full[AREAW-1:0];
               i_in    = '0;
               j_in    = '0;
               sum_in  = '0;
               if (req_bad) begin
                  res_in   = '0;
                  bad_in   = 1'b1;
                  state_in = ST_HOLD;
               end else begin
                  bad_in   = 1'b0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (j_ff == lim_ff) begin
               j_in = '0;
               i_in = i_ff + 1'b1;
               if (i_ff == lim_ff) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_DRAIN: state_in = ST_START;
         ST_START: state_in = ST_DIV;
         ST_DIV: begin
            if (div_done) begin
               res_in   = quotient[PIX_W-1:0];
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pixel_in = res_ff;
               rsp_bad_in   = bad_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radius_ff    <= RADIUS_RST;
         width_ff     <= DIM_RST;
         height_ff    <= DIM_RST;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         radius_ff    <= radius_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      row_ff       <= row_in;
      col_ff       <= col_in;
      r_ff         <= r_in;
      lim_ff       <= lim_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      area_ff      <= area_in;
      sum_ff       <= sum_in;
      res_ff       <= res_in;
      bad_ff       <= bad_in;
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   // Frame memory
   gbmf_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
   ) u_frame (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_pixel_in),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Window sum / area
   gbmf_div #(
      .DVD_W (SUMW),
      .DVS_W (AREAW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (area_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_out   = rsp_pixel_ff;
   assign rsp_bad_request = rsp_bad_ff;

endmodule

// ===== rtl/gbmf_chk.sv =====
// Port-level checker for the box mean filter, bound to the top level.
// Depends on gbmf_pkg.
`timescale 1ns / 1ps
module gbmf_chk
   import gbmf_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  req_mode,
   input logic [COORD_W-1:0]    req_row,
   input logic [COORD_W-1:0]    req_col,
   input logic [PIX_W-1:0]      req_pixel_in,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [PIX_W-1:0]      rsp_pixel_out,
   input logic                  rsp_bad_request,
   input logic                  csr_valid,
   input logic                  csr_ready,
   input logic [CSR_IDX_W-1:0]  csr_index,
   input logic [CSR_DATA_W-1:0] csr_wdata
);

   // Stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_out)
                                 && $stable(rsp_bad_request))
      else $error("result beat changed while stalled");

   // A flagged request carries pixel 0
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_request |-> rsp_pixel_out == '0)
      else $error("bad request with nonzero pixel");

   // A filter beat makes the block busy
   a_filter_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode == MODE_FILTER |=> !req_ready)
      else $error("ready after filter beat");

   // After a load beat the block is still ready
   a_load_fast: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode == MODE_LOAD |=> req_ready)
      else $error("not ready after load beat");

   // No result right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind grayscale_box_mean_filter gbmf_chk u_gbmf_chk (.*);

// ===== tb/grayscale_box_mean_filter_test.sv =====
// Self-checking testbench for grayscale_box_mean_filter: loads, window means, off-image flags.
// Depends on gbmf_pkg and the grayscale_box_mean_filter RTL. Holds its own frame copy as predictor.
`timescale 1ns / 1ps
module grayscale_box_mean_filter_test;
   import gbmf_pkg::*;

   localparam int DIM           = MAX_DIM_DEF;
   // longest filter: a 15x15 window read and a 16-bit divide, plus overhead
   localparam int SETTLE_CYCLES = 300;
   localparam int TIMEOUT_NS    = 40_000_000;
   localparam int PHASE_ITEMS   = 20;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             bad;
   } mean_beat_type;

   // Predictor and result checker
   class mean_scoreboard_type;
      logic [PIX_W-1:0]      frame [DIM*DIM];
      logic [RADIUS_W-1:0]   radius;
      logic [CSR_DATA_W-1:0] width;
      logic [CSR_DATA_W-1:0] height;
      mean_beat_type         pending_means [$];
      int unsigned           n_errors, n_results, n_loads, n_means, n_off_image;

      function new();
         radius = RADIUS_RST;
         width  = DIM_RST;
         height = DIM_RST;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_RADIUS: radius = data[RADIUS_W-1:0];
            CSR_WIDTH:  width  = data;
            CSR_HEIGHT: height = data;
            default: ;
         endcase
      endfunction

      function int img_w();
         return (width > DIM) ? DIM : int'(width);
      endfunction

      function int img_h();
         return (height > DIM) ? DIM : int'(height);
      endfunction

      function int eff_radius();
         return (radius > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : int'(radius);
      endfunction

      // out-of-frame neighbors read coordinate 0, not the nearest edge
      function int fold(int c, int dim);
         return (c < 0 || c >= dim) ? 0 : c;
      endfunction

      function bit off_image(int row, int col);
         return row >= img_h() || col >= img_w();
      endfunction

      function int pending();
         return pending_means.size();
      endfunction

      function void note_request(logic mode, logic [COORD_W-1:0] row, logic [COORD_W-1:0] col,
                                 logic [PIX_W-1:0] pix);
         mean_beat_type beat;
         int unsigned   sum;
         int            r, i, j, y, x;
         if (mode == MODE_LOAD) begin
            frame[int'(row) * DIM + int'(col)] = pix;
            n_loads++;
            return;
         end
         n_means++;
         if (off_image(row, col)) begin
            n_off_image++;
            beat.pixel = '0;
            beat.bad   = 1'b1;
         end else begin
            r   = eff_radius();
            sum = 0;
            for (i = -r; i <= r; i++) begin
               y = fold(int'(row) + i, img_h());
               for (j = -r; j <= r; j++) begin
                  x = fold(int'(col) + j, img_w());
                  sum += frame[y * DIM + x];
               end
            end
            sum = sum / ((2 * r + 1) * (2 * r + 1));
            beat.pixel = sum[PIX_W-1:0];
            beat.bad   = 1'b0;
         end
         pending_means.push_back(beat);
      endfunction

      function void check_result(logic [PIX_W-1:0] pix, logic bad);
         mean_beat_type beat;
         n_results++;
         if (pending_means.size() == 0) begin
            $error("result beat with nothing pending: pixel_out %0d bad_request %0d", pix, bad);
            n_errors++;
            return;
         end
         beat = pending_means.pop_front();
         if (pix !== beat.pixel) begin
            $error("pixel_out mismatch: expected %0d, actual %0d", beat.pixel, pix);
            n_errors++;
         end
         if (bad !== beat.bad) begin
            $error("bad_request mismatch: expected %0d, actual %0d", beat.bad, bad);
            n_errors++;
         end
      endfunction
   endclass

   logic                  clock           = 1'b0;
   logic                  reset           = 1'b1;
   logic                  req_valid       = 1'b0;
   logic                  req_ready;
   logic                  req_mode        = MODE_LOAD;
   logic [COORD_W-1:0]    req_row         = '0;
   logic [COORD_W-1:0]    req_col         = '0;
   logic [PIX_W-1:0]      req_pixel_in    = '0;
   logic                  rsp_valid;
   logic                  rsp_ready       = 1'b0;
   logic [PIX_W-1:0]      rsp_pixel_out;
   logic                  rsp_bad_request;
   logic                  csr_valid       = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index       = '0;
   logic [CSR_DATA_W-1:0] csr_wdata       = '0;

   mean_scoreboard_type sb;
   bit                  loaded [DIM*DIM];
   bit                  tx_rush, rx_rush;
   int unsigned         n_settings;

   grayscale_box_mean_filter u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_row         (req_row),
      .req_col         (req_col),
      .req_pixel_in    (req_pixel_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_out   (rsp_pixel_out),
      .rsp_bad_request (rsp_bad_request),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int draw_gap(bit rush);
      return rush ? 0 : $urandom_range(0, 11);
   endfunction

   // mostly random gray levels, with black and white mixed in
   function automatic logic [PIX_W-1:0] draw_pixel();
      if ($urandom_range(0, 7) == 0)
         return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      return PIX_W'($urandom_range(0, 255));
   endfunction

   // coordinate near the low edge, near the high edge, inside, or anywhere
   function automatic int pick_coord(int dim, int r);
      int span;
      if (dim == 0)
         return $urandom_range(0, 255);
      span = r + 1;
      case ($urandom_range(0, 3))
         0:       return $urandom_range(0, (dim - 1 < span) ? dim - 1 : span);
         1:       return $urandom_range((dim - 1 > span) ? dim - 1 - span : 0, dim - 1);
         2:       return $urandom_range(0, dim - 1);
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   // one request beat: optional idle, then hold valid until accepted
   task automatic send_req(logic mode, logic [COORD_W-1:0] row, logic [COORD_W-1:0] col,
                           logic [PIX_W-1:0] pix);
      int gap;
      gap = draw_gap(tx_rush);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_mode     <= mode;
      req_row      <= row;
      req_col      <= col;
      req_pixel_in <= pix;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      sb.note_request(mode, row, col, pix);
      if (mode == MODE_LOAD)
         loaded[int'(row) * DIM + int'(col)] = 1'b1;
   endtask

   // load every pixel the window will read, then ask for the mean
   task automatic request_mean(int row, int col);
      int r, i, j, y, x;
      if (!sb.off_image(row, col)) begin
         r = sb.eff_radius();
         for (i = -r; i <= r; i++) begin
            y = sb.fold(row + i, sb.img_h());
            for (j = -r; j <= r; j++) begin
               x = sb.fold(col + j, sb.img_w());
               if (!loaded[y * DIM + x])
                  send_req(MODE_LOAD, COORD_W'(y), COORD_W'(x), draw_pixel());
            end
         end
      end
      send_req(MODE_FILTER, COORD_W'(row), COORD_W'(col), PIX_W'($urandom_range(0, 255)));
   endtask

   // raise csr_valid and wait for the beat; caller lowers it
   task automatic put_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   task automatic set_regs(int r, int w, int h, bit poke_unused);
      logic [CSR_DATA_W-1:0] rdata;
      // junk in the upper bits of the radius write must be dropped
      rdata = CSR_DATA_W'($urandom_range(0, 511));
      rdata[RADIUS_W-1:0] = RADIUS_W'(r);
      put_reg(CSR_RADIUS, rdata);
      put_reg(CSR_WIDTH, CSR_DATA_W'(w));
      if (poke_unused)
         put_reg(CSR_UNUSED, CSR_DATA_W'($urandom_range(0, 511)));
      put_reg(CSR_HEIGHT, CSR_DATA_W'(h));
      csr_valid <= 1'b0;
      n_settings++;
   endtask

   // wait for all results, then let trailing loads finish
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_item();
      int r, row, col;
      r = sb.eff_radius();
      if ($urandom_range(0, 99) < 40) begin
         if ($urandom_range(0, 9) < 7) begin
            row = pick_coord(sb.img_h(), r);
            col = pick_coord(sb.img_w(), r);
         end else begin
            row = $urandom_range(0, 255);
            col = $urandom_range(0, 255);
         end
         send_req(MODE_LOAD, COORD_W'(row), COORD_W'(col), draw_pixel());
      end else begin
         request_mean(pick_coord(sb.img_h(), r), pick_coord(sb.img_w(), r));
      end
   endtask

   task automatic run_phase(int r, int w, int h);
      int k;
      settle();
      set_regs(r, w, h, $urandom_range(0, 3) == 0);
      for (k = 0; k < PHASE_ITEMS; k++) begin
         if (k % 10 == 0) begin
            tx_rush = ($urandom_range(0, 3) == 0);
            rx_rush = ($urandom_range(0, 3) == 0);
         end
         random_item();
      end
   endtask

   // Result sink: random stall before each beat
   initial begin : rsp_sink
      int stall;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = draw_gap(rx_rush);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         sb.check_result(rsp_pixel_out, rsp_bad_request);
      end
   end

   // Stimulus
   initial begin : stimulus
      int p;
      // large radii run on small images so the windows stay cheap to load
      int ph_r [8] = '{7, 0, 3, 5, 7, 2, 1, 6};
      int ph_w [8] = '{6, 256, 5, 4, 1, 40, 0, 40};
      int ph_h [8] = '{6, 256, 7, 5, 20, 2, 30, 0};
      sb = new();
      tx_rush = 1'b0;
      rx_rush = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset settings: radius 1, full 256 x 256 frame
      send_req(MODE_LOAD, 8'd0, 8'd0, 8'd255);
      send_req(MODE_LOAD, 8'd0, 8'd1, 8'd255);
      send_req(MODE_LOAD, 8'd1, 8'd0, 8'd255);
      send_req(MODE_LOAD, 8'd1, 8'd1, 8'd255);
      request_mean(0, 0);
      send_req(MODE_LOAD, 8'd0, 8'd0, 8'd0);
      request_mean(0, 0);
      request_mean(255, 255);
      request_mean(0, 255);
      request_mean(255, 0);
      send_req(MODE_LOAD, 8'd255, 8'd255, 8'd128);
      request_mean(255, 255);

      // single-pixel image, no window
      settle();
      set_regs(0, 1, 1, 1'b1);
      request_mean(0, 0);
      request_mean(0, 1);
      request_mean(1, 0);
      request_mean(255, 255);

      // zero width: every request is off the image
      settle();
      set_regs(3, 0, 256, 1'b0);
      request_mean(0, 0);
      request_mean(10, 255);

      // oversize dimensions saturate to the full frame
      settle();
      set_regs(1, 511, 300, 1'b0);
      request_mean(0, 0);
      request_mean(255, 255);
      request_mean(128, 7);

      // random phases over fixed and drawn settings
      for (p = 0; p < 8; p++)
         run_phase(ph_r[p], ph_w[p], ph_h[p]);
      for (p = 0; p < 4; p++)
         run_phase($urandom_range(0, 7), $urandom_range(1, 8), $urandom_range(1, 8));

      settle();
      $display("Run covered %0d pixel loads and %0d mean requests (%0d off the image)",
               sb.n_loads, sb.n_means, sb.n_off_image);
      $display("over %0d register settings; %0d result beats checked, %0d mismatches",
               n_settings, sb.n_results, sb.n_errors);
      if (sb.n_errors == 0 && sb.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Run limit
   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/gbmf_pkg.sv
rtl/gbmf_ram.sv
rtl/gbmf_div.sv
rtl/grayscale_box_mean_filter.sv
rtl/gbmf_chk.sv
tb/grayscale_box_mean_filter_test.sv
